### rtl/ssi_pkg.sv
// ----------------------------------------------------------------------------
// ssi_pkg
// Shared widths, codes and record types of the segment/sphere intersection
// unit.
// ----------------------------------------------------------------------------
package ssi_pkg;

  localparam int CW        = 32;              // coordinate width
  localparam int FRAC_BITS = 16;
  localparam int RW        = CW - 1;          // radius width
  localparam int RRW       = 2 * RW;          // radius squared
  localparam int DW        = CW + 1;          // difference width, signed
  localparam int PW        = 2 * CW + 2;      // |a|, |h|, |c|
  localparam int LW        = PW / 2;          // limb of a wide product
  localparam int HW        = PW + 2;          // signed h and c
  localparam int XW        = 2 * PW;          // h*h and a*c
  localparam int DMW       = 4 * CW;          // discriminant magnitude
  localparam int SQW       = DMW / 2;         // square root width
  localparam int SQS       = SQW;             // square root stages
  localparam int NW        = HW;              // signed root numerator
  localparam int NMW       = NW - 1;          // its magnitude
  localparam int NLW       = (NMW + 1) / 2;
  localparam int NHW       = NMW - NLW;
  localparam int PRW       = CW + NMW;        // |d_i * n|
  localparam int NUMW      = PRW + 2;         // 2|prod| + a
  localparam int DVW       = PW + 1;          // 2a
  localparam int QW        = NW;              // quotient width and stages
  localparam int PTW       = QW + 2;          // unsaturated hit coordinate
  localparam int TOL       = ((1 << FRAC_BITS) + 5000) / 10000;
  localparam int FDEPTH    = 4;
  localparam int FAW       = $clog2(FDEPTH);

  localparam logic [RW-1:0] RADIUS_RST = RW'(1 << FRAC_BITS);

  localparam logic [1:0] ST_POINT = 2'd0;
  localparam logic [1:0] ST_NONE  = 2'd1;
  localparam logic [1:0] ST_DEGEN = 2'd2;

  localparam logic [2:0] K_DEGEN  = 3'd0;
  localparam logic [2:0] K_MISS   = 3'd1;
  localparam logic [2:0] K_ONE    = 3'd2;
  localparam logic [2:0] K_FIRST  = 3'd3;
  localparam logic [2:0] K_SECOND = 3'd4;

  typedef logic [2:0][CW-1:0] vec3_t;
  typedef logic [2:0][DW-1:0] dvec3_t;

  typedef struct packed {
    vec3_t          pa;
    vec3_t          pb;
    dvec3_t         d;
    logic [PW-1:0]  a;
    logic [HW-1:0]  h;
    logic           degen;
    logic           dneg;
    logic           dzero;
  } fpay_t;

  typedef struct packed {
    vec3_t          pa;
    vec3_t          pb;
    dvec3_t         d;
    logic [PW-1:0]  a;
    logic [NW-1:0]  n1;
    logic [NW-1:0]  n2;
    logic           degen;
    logic           dneg;
    logic           dzero;
  } qent_t;

  typedef struct packed {
    logic [2:0]     kind;
    logic [2:0]     sg;
    vec3_t          pa;
    vec3_t          pb;
  } btag_t;

endpackage

### rtl/segment_sphere_intersection_unit.sv
// ----------------------------------------------------------------------------
// segment_sphere_intersection_unit
// Intersects a segment with a sphere in signed Q15.16 and reports hit points.
// ----------------------------------------------------------------------------
// A query is taken whenever start is high and busy is low. The front end
// forms the quadratic and its discriminant and takes the square root in a
// 64-stage pipeline; a four-entry queue decouples it from the back end, which
// issues one root per cycle into three 68-stage dividers. A query with two
// roots on the line issues both from its queue entry before it is popped, any
// other query issues one root, so the unit takes one query per cycle unless
// busy is high; queries with two roots slow the back end and can fill the
// queue. Each result is shown for one cycle with out_valid; the receiver
// cannot stall, and busy rises only while the queue is full. Write the radius
// only while no query is in flight.
// ----------------------------------------------------------------------------
module segment_sphere_intersection_unit (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [ssi_pkg::CW-1:0]  in_start_x,
  input  logic [ssi_pkg::CW-1:0]  in_start_y,
  input  logic [ssi_pkg::CW-1:0]  in_start_z,
  input  logic [ssi_pkg::CW-1:0]  in_end_x,
  input  logic [ssi_pkg::CW-1:0]  in_end_y,
  input  logic [ssi_pkg::CW-1:0]  in_end_z,
  input  logic [ssi_pkg::CW-1:0]  in_center_x,
  input  logic [ssi_pkg::CW-1:0]  in_center_y,
  input  logic [ssi_pkg::CW-1:0]  in_center_z,
  input  logic                    cfg_we,
  input  logic [ssi_pkg::RW-1:0]  cfg_radius,
  output logic                    out_valid,
  output logic [ssi_pkg::CW-1:0]  out_hit_x,
  output logic [ssi_pkg::CW-1:0]  out_hit_y,
  output logic [ssi_pkg::CW-1:0]  out_hit_z,
  output logic [1:0]              out_status,
  output logic                    out_last
);
  import ssi_pkg::*;

  logic [RW-1:0] radius_r;
  vec3_t         pa, pb, pc;
  logic          q_full, q_empty, q_push, q_pop;
  qent_t         q_wdata, q_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RST;
    end else if (cfg_we) begin
      radius_r <= cfg_radius;
    end
  end

  assign pa = {in_start_z, in_start_y, in_start_x};
  assign pb = {in_end_z, in_end_y, in_end_x};
  assign pc = {in_center_z, in_center_y, in_center_x};

  ssi_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .in_pa  (pa),
    .in_pb  (pb),
    .in_pc  (pc),
    .radius (radius_r),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_wdata)
  );

  ssi_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  ssi_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_data     (q_rdata),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_hit_x  (out_hit_x),
    .out_hit_y  (out_hit_y),
    .out_hit_z  (out_hit_z),
    .out_status (out_status),
    .out_last   (out_last)
  );

endmodule

### rtl/ssi_sqrt.sv
// ----------------------------------------------------------------------------
// ssi_sqrt
// Pipelined integer square root, one result bit per stage, floor result.
// ----------------------------------------------------------------------------
module ssi_sqrt (
  input  logic                     clk,
  input  logic                     en,
  input  logic [ssi_pkg::DMW-1:0]  x_i,
  output logic [ssi_pkg::SQW-1:0]  root_o
);
  import ssi_pkg::*;

  logic [SQW+1:0] rem_r  [SQS];
  logic [SQW-1:0] root_r [SQS];
  logic [DMW-1:0] x_r    [SQS];

  for (genvar k = 0; k < SQS; k++) begin : g_st
    logic [SQW+1:0] rem_in;
    logic [SQW-1:0] root_in;
    logic [DMW-1:0] x_in;
    logic [SQW+3:0] r4;
    logic [SQW+3:0] trial;
    logic [SQW+3:0] diff;
    logic           ge;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign x_in    = x_i;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign x_in    = x_r[k-1];
    end

    assign r4    = {rem_in, x_in[DMW-1 -: 2]};
    assign trial = {2'b00, root_in, 2'b01};
    assign diff  = r4 - trial;
    assign ge    = (r4 >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? diff[SQW+1:0] : r4[SQW+1:0];
        root_r[k] <= {root_in[SQW-2:0], ge};
        x_r[k]    <= {x_in[DMW-3:0], 2'b00};
      end
    end
  end

  assign root_o = root_r[SQS-1];

endmodule

### rtl/ssi_front.sv
// ----------------------------------------------------------------------------
// ssi_front
// Front end: accept a query, form a, h, c and the discriminant, take its
// square root, classify and hand root numerators to the queue.
// ----------------------------------------------------------------------------
module ssi_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  ssi_pkg::vec3_t          in_pa,
  input  ssi_pkg::vec3_t          in_pb,
  input  ssi_pkg::vec3_t          in_pc,
  input  logic [ssi_pkg::RW-1:0]  radius,
  input  logic                    q_full,
  output logic                    q_push,
  output ssi_pkg::qent_t          q_data
);
  import ssi_pkg::*;

  logic adv;

  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  fpay_t p1_r, p2_r, p3_r, p4_r, p5_r, p6_r;
  fpay_t p1_nxt, p3_nxt, p4_nxt, p6_nxt;
  logic [DW-1:0] f1_r [3];
  logic [PW-1:0] dd2_r [3];
  logic [PW-1:0] df2_r [3];
  logic [PW-1:0] ff2_r [3];
  logic [RRW-1:0] rr2_r;
  logic [HW-1:0] c3_r;
  logic [PW-1:0] phh4_r, phl4_r, pll4_r;
  logic [PW-1:0] ahh4_r, ahl4_r, alh4_r, all4_r;
  logic c4neg_r, c5neg_r;
  logic [XW-1:0] h2_r, ac_r;
  logic [DMW-1:0] dm6_r;

  logic [HW-1:0] h_mag, c_mag;
  logic [XW:0] dsum;

  logic  sv_r [SQS];
  fpay_t sp_r [SQS];
  logic [SQW-1:0] root;
  logic [NW-1:0] nh;

  assign adv  = !(sv_r[SQS-1] && q_full);
  assign busy = !adv;

  assign h_mag = p3_r.h[HW-1] ? (~p3_r.h + 1'b1) : p3_r.h;
  assign c_mag = c3_r[HW-1] ? (~c3_r + 1'b1) : c3_r;
  assign dsum  = c5neg_r ? ({1'b0, h2_r} + {1'b0, ac_r}) : ({1'b0, h2_r} - {1'b0, ac_r});

  always_comb begin
    p1_nxt    = '0;
    p1_nxt.pa = in_pa;
    p1_nxt.pb = in_pb;
    for (int i = 0; i < 3; i++) begin
      p1_nxt.d[i] = DW'($signed(in_pb[i])) - DW'($signed(in_pa[i]));
    end

    p3_nxt   = p2_r;
    p3_nxt.a = dd2_r[0] + dd2_r[1] + dd2_r[2];
    p3_nxt.h = HW'($signed(df2_r[0])) + HW'($signed(df2_r[1])) + HW'($signed(df2_r[2]));

    p4_nxt       = p3_r;
    p4_nxt.degen = (p3_r.a == '0);

    p6_nxt       = p5_r;
    p6_nxt.dneg  = !c5neg_r && dsum[XW];
    p6_nxt.dzero = (dsum[DMW-1:0] == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      for (int k = 0; k < SQS; k++) begin
        sv_r[k] <= 1'b0;
      end
    end else if (adv) begin
      v1_r <= start;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
      sv_r[0] <= v6_r;
      for (int k = 1; k < SQS; k++) begin
        sv_r[k] <= sv_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_r <= p1_nxt;
      for (int i = 0; i < 3; i++) begin
        f1_r[i] <= DW'($signed(in_pa[i])) - DW'($signed(in_pc[i]));
      end

      p2_r <= p1_r;
      for (int i = 0; i < 3; i++) begin
        dd2_r[i] <= PW'($signed(p1_r.d[i])) * PW'($signed(p1_r.d[i]));
        df2_r[i] <= PW'($signed(p1_r.d[i])) * PW'($signed(f1_r[i]));
        ff2_r[i] <= PW'($signed(f1_r[i])) * PW'($signed(f1_r[i]));
      end
      rr2_r <= RRW'(radius) * RRW'(radius);

      p3_r <= p3_nxt;
      c3_r <= HW'($signed(ff2_r[0])) + HW'($signed(ff2_r[1])) + HW'($signed(ff2_r[2]))
              - HW'(rr2_r);

      p4_r    <= p4_nxt;
      c4neg_r <= c3_r[HW-1];
      phh4_r  <= PW'(h_mag[PW-1:LW]) * PW'(h_mag[PW-1:LW]);
      phl4_r  <= PW'(h_mag[PW-1:LW]) * PW'(h_mag[LW-1:0]);
      pll4_r  <= PW'(h_mag[LW-1:0]) * PW'(h_mag[LW-1:0]);
      ahh4_r  <= PW'(p3_r.a[PW-1:LW]) * PW'(c_mag[PW-1:LW]);
      ahl4_r  <= PW'(p3_r.a[PW-1:LW]) * PW'(c_mag[LW-1:0]);
      alh4_r  <= PW'(p3_r.a[LW-1:0]) * PW'(c_mag[PW-1:LW]);
      all4_r  <= PW'(p3_r.a[LW-1:0]) * PW'(c_mag[LW-1:0]);

      p5_r    <= p4_r;
      c5neg_r <= c4neg_r;
      h2_r    <= (XW'(phh4_r) << PW) + (XW'(phl4_r) << (LW + 1)) + XW'(pll4_r);
      ac_r    <= (XW'(ahh4_r) << PW) + ((XW'(ahl4_r) + XW'(alh4_r)) << LW) + XW'(all4_r);

      p6_r  <= p6_nxt;
      dm6_r <= dsum[DMW-1:0];

      sp_r[0] <= p6_r;
      for (int k = 1; k < SQS; k++) begin
        sp_r[k] <= sp_r[k-1];
      end
    end
  end

  ssi_sqrt u_sqrt (
    .clk    (clk),
    .en     (adv),
    .x_i    (dm6_r),
    .root_o (root)
  );

  assign nh = ~sp_r[SQS-1].h + 1'b1;

  always_comb begin
    q_data.pa    = sp_r[SQS-1].pa;
    q_data.pb    = sp_r[SQS-1].pb;
    q_data.d     = sp_r[SQS-1].d;
    q_data.a     = sp_r[SQS-1].a;
    q_data.n1    = nh + NW'(root);
    q_data.n2    = nh - NW'(root);
    q_data.degen = sp_r[SQS-1].degen;
    q_data.dneg  = sp_r[SQS-1].dneg;
    q_data.dzero = sp_r[SQS-1].dzero;
  end

  assign q_push = sv_r[SQS-1] && adv;

endmodule

### rtl/ssi_fifo.sv
// ----------------------------------------------------------------------------
// ssi_fifo
// Short queue between the front end and the root evaluation back end.
// ----------------------------------------------------------------------------
module ssi_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  ssi_pkg::qent_t  wdata,
  input  logic            pop,
  output ssi_pkg::qent_t  rdata,
  output logic            full,
  output logic            empty
);
  import ssi_pkg::*;

  qent_t          mem_r [FDEPTH];
  logic [FAW-1:0] wp_r, rp_r;
  logic [FAW:0]   cnt_r;

  assign full  = (cnt_r == (FAW+1)'(FDEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (FAW+1)'(push) - (FAW+1)'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full || pop) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty) else $error("queue underflow");

endmodule

### rtl/ssi_div.sv
// ----------------------------------------------------------------------------
// ssi_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module ssi_div (
  input  logic                     clk,
  input  logic [ssi_pkg::NUMW-1:0] num_i,
  input  logic [ssi_pkg::DVW-1:0]  div_i,
  output logic [ssi_pkg::QW-1:0]   q_o
);
  import ssi_pkg::*;

  logic [DVW-1:0] rem_r [QW];
  logic [QW-1:0]  num_r [QW];
  logic [DVW-1:0] dv_r  [QW];

  for (genvar k = 0; k < QW; k++) begin : g_st
    logic [DVW-1:0] rem_in;
    logic [QW-1:0]  num_in;
    logic [DVW-1:0] dv_in;
    logic [DVW:0]   t;
    logic [DVW:0]   diff;
    logic           ge;

    if (k == 0) begin : g_first
      assign rem_in = DVW'(num_i[NUMW-1:QW]);
      assign num_in = num_i[QW-1:0];
      assign dv_in  = div_i;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign num_in = num_r[k-1];
      assign dv_in  = dv_r[k-1];
    end

    assign t    = {rem_in, num_in[QW-1]};
    assign diff = t - {1'b0, dv_in};
    assign ge   = (t >= {1'b0, dv_in});

    always_ff @(posedge clk) begin
      rem_r[k] <= ge ? diff[DVW-1:0] : t[DVW-1:0];
      num_r[k] <= {num_in[QW-2:0], ge};
      dv_r[k]  <= dv_in;
    end
  end

  assign q_o = num_r[QW-1];

endmodule

### rtl/ssi_back.sv
// ----------------------------------------------------------------------------
// ssi_back
// Back end: issue one root per cycle, scale by the direction, divide by a
// with rounding, test against the segment bounds and emit results.
// ----------------------------------------------------------------------------
module ssi_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_empty,
  input  ssi_pkg::qent_t         q_data,
  output logic                   q_pop,
  output logic                   out_valid,
  output logic [ssi_pkg::CW-1:0] out_hit_x,
  output logic [ssi_pkg::CW-1:0] out_hit_y,
  output logic [ssi_pkg::CW-1:0] out_hit_z,
  output logic [1:0]             out_status,
  output logic                   out_last
);
  import ssi_pkg::*;

  logic       phase_r;
  logic [2:0] kind;
  logic       issue;
  logic [2:0] sg;

  logic          v1_r;
  btag_t         t1_r;
  dvec3_t        d1_r;
  logic [PW-1:0] a1_r;
  logic [NW-1:0] n1_r;

  logic           v2_r;
  btag_t          t2_r;
  logic [PW-1:0]  a2_r;
  logic [CW+NLW-1:0] plo2_r [3];
  logic [CW+NHW-1:0] phi2_r [3];

  logic           v3_r;
  btag_t          t3_r;
  logic [NUMW-1:0] num3_r [3];
  logic [DVW-1:0] div3_r;

  logic  tv_r [QW];
  btag_t tg_r [QW];
  logic [QW-1:0] q [3];

  logic          rv_r, hv_r;
  logic [2:0]    rk_r, hk_r;
  logic          rkept_r, hkept_r;
  vec3_t         rhit_r, hhit_r;

  logic [NMW-1:0] n_mag;
  logic [CW-1:0]  d_mag [3];
  logic           kept;
  vec3_t          hit;

  logic          emit;
  logic [1:0]    st;
  logic          lst;
  logic          use_hit;

  logic          out_valid_r;
  vec3_t         out_hit_r;
  logic [1:0]    out_status_r;
  logic          out_last_r;

  always_comb begin
    if (q_data.degen) begin
      kind = K_DEGEN;
    end else if (q_data.dneg) begin
      kind = K_MISS;
    end else if (q_data.dzero) begin
      kind = K_ONE;
    end else if (phase_r) begin
      kind = K_SECOND;
    end else begin
      kind = K_FIRST;
    end
  end

  assign issue = !q_empty;
  assign q_pop = issue && (kind != K_FIRST);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sg[i] = q_data.d[i][DW-1] ^ (phase_r ? q_data.n2[NW-1] : q_data.n1[NW-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;
    end else if (issue && kind == K_FIRST) begin
      phase_r <= 1'b1;
    end else if (issue && kind == K_SECOND) begin
      phase_r <= 1'b0;
    end
  end

  assign n_mag = n1_r[NW-1] ? NMW'(~n1_r + 1'b1) : n1_r[NMW-1:0];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_mag[i] = d1_r[i][DW-1] ? CW'(~d1_r[i] + 1'b1) : d1_r[i][CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      for (int k = 0; k < QW; k++) begin
        tv_r[k] <= 1'b0;
      end
    end else begin
      v1_r <= issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
      tv_r[0] <= v3_r;
      for (int k = 1; k < QW; k++) begin
        tv_r[k] <= tv_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    t1_r.kind <= kind;
    t1_r.sg   <= sg;
    t1_r.pa   <= q_data.pa;
    t1_r.pb   <= q_data.pb;
    d1_r      <= q_data.d;
    a1_r      <= q_data.a;
    n1_r      <= phase_r ? q_data.n2 : q_data.n1;

    t2_r <= t1_r;
    a2_r <= a1_r;
    for (int i = 0; i < 3; i++) begin
      plo2_r[i]  <= (CW+NLW)'(d_mag[i]) * (CW+NLW)'(n_mag[NLW-1:0]);
      phi2_r[i]  <= (CW+NHW)'(d_mag[i]) * (CW+NHW)'(n_mag[NMW-1:NLW]);
    end

    t3_r   <= t2_r;
    div3_r <= {a2_r, 1'b0};
    for (int i = 0; i < 3; i++) begin
      num3_r[i] <= {(PRW'(phi2_r[i]) << NLW) + PRW'(plo2_r[i]), 1'b0} + NUMW'(a2_r);
    end

    tg_r[0] <= t3_r;
    for (int k = 1; k < QW; k++) begin
      tg_r[k] <= tg_r[k-1];
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_ax
    ssi_div u_div (
      .clk   (clk),
      .num_i (num3_r[i]),
      .div_i (div3_r),
      .q_o   (q[i])
    );
  end

  always_comb begin
    logic signed [PTW-1:0] p, lo, hi, qs, ea, eb;
    kept = 1'b1;
    hit  = '0;
    for (int i = 0; i < 3; i++) begin
      qs = tg_r[QW-1].sg[i] ? -$signed(PTW'(q[i])) : $signed(PTW'(q[i]));
      ea = PTW'($signed(tg_r[QW-1].pa[i]));
      eb = PTW'($signed(tg_r[QW-1].pb[i]));
      p  = ea + qs;
      lo = ((ea < eb) ? ea : eb) - PTW'(TOL);
      hi = ((ea < eb) ? eb : ea) + PTW'(TOL);
      if (p < lo || p > hi) begin
        kept = 1'b0;
      end
      if (p[PTW-1:CW-1] == '0 || p[PTW-1:CW-1] == '1) begin
        hit[i] = p[CW-1:0];
      end else if (p[PTW-1]) begin
        hit[i] = {1'b1, {(CW-1){1'b0}}};
      end else begin
        hit[i] = {1'b0, {(CW-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rv_r <= 1'b0;
      hv_r <= 1'b0;
    end else begin
      rv_r <= tv_r[QW-1];
      hv_r <= rv_r;
    end
  end

  always_ff @(posedge clk) begin
    rk_r    <= tg_r[QW-1].kind;
    rkept_r <= kept;
    rhit_r  <= hit;
    hk_r    <= rk_r;
    hkept_r <= rkept_r;
    hhit_r  <= rhit_r;
  end

  always_comb begin
    emit    = 1'b0;
    st      = ST_NONE;
    lst     = 1'b1;
    use_hit = 1'b0;
    if (hv_r) begin
      case (hk_r)
        K_DEGEN: begin
          emit = 1'b1;
          st   = ST_DEGEN;
        end
        K_MISS: begin
          emit = 1'b1;
        end
        K_ONE: begin
          emit    = 1'b1;
          st      = hkept_r ? ST_POINT : ST_NONE;
          use_hit = hkept_r;
        end
        K_FIRST: begin
          if (hkept_r) begin
            emit    = 1'b1;
            st      = ST_POINT;
            use_hit = 1'b1;
            lst     = !rkept_r;
          end else begin
            emit = !rkept_r;
          end
        end
        K_SECOND: begin
          emit    = hkept_r;
          st      = ST_POINT;
          use_hit = 1'b1;
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    out_hit_r    <= use_hit ? hhit_r : '0;
    out_status_r <= st;
    out_last_r   <= lst;
  end

  assign out_valid  = out_valid_r;
  assign out_hit_x  = out_hit_r[0];
  assign out_hit_y  = out_hit_r[1];
  assign out_hit_z  = out_hit_r[2];
  assign out_status = out_status_r;
  assign out_last   = out_last_r;

  a_pair: assert property (@(posedge clk) disable iff (!rst_n)
    hv_r && hk_r == K_FIRST |-> rv_r && rk_r == K_SECOND)
    else $error("first root not followed by its second root");
  a_phase: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> !q_empty && !q_data.degen && !q_data.dneg && !q_data.dzero)
    else $error("second root issue lost its queue entry");
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != ST_POINT |-> out_last_r)
    else $error("status result not marked last");

endmodule

### test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for segment_sphere_intersection_unit. Queries are sent
// through the start/busy handshake with random gaps. Each transfer is run
// through an exact wide-integer predictor of the quadratic solve, and every
// out_valid result is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  import ssi_pkg::*;

  typedef logic signed [255:0] wide_t;

  typedef struct {
    logic [CW-1:0] hx, hy, hz;
    logic [1:0]    st;
    logic          lst;
  } hit_t;

  logic          clk, rst_n, start, busy, cfg_we;
  logic [CW-1:0] in_start_x, in_start_y, in_start_z, in_end_x, in_end_y, in_end_z;
  logic [CW-1:0] in_center_x, in_center_y, in_center_z;
  logic [RW-1:0] cfg_radius;
  logic          out_valid, out_last;
  logic [CW-1:0] out_hit_x, out_hit_y, out_hit_z;
  logic [1:0]    out_status;

  hit_t          pending_hits[$];
  logic [RW-1:0] model_radius;
  int            n_errors, n_queries, n_results, n_points, n_misses, n_degen, idle_cycles;

  segment_sphere_intersection_unit u_dut (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  function automatic wide_t isqrt(wide_t v);
    wide_t r, cand;
    r = 0;
    for (int i = 127; i >= 0; i--) begin
      cand = r | (wide_t'(1) << i);
      if (cand * cand <= v) r = cand;
    end
    return r;
  endfunction

  function automatic logic [CW-1:0] clamp(wide_t p);
    if (p > wide_t'(32'sh7fffffff)) return 32'h7fffffff;
    if (p < -wide_t'(64'sh80000000)) return 32'h80000000;
    return p[CW-1:0];
  endfunction

  // Work out the hits of one query and queue them.
  task automatic predict_hits(logic [CW-1:0] pa[3], logic [CW-1:0] pb[3],
                              logic [CW-1:0] pc[3]);
    wide_t a_i[3], b_i[3], dv[3], fv[3], a, h, c, disc, s, num, prod, q, p;
    wide_t rr;
    hit_t  found[$];
    hit_t  e;
    int    roots;
    logic  keep;
    a = 0; h = 0; c = 0;
    for (int i = 0; i < 3; i++) begin
      a_i[i] = $signed(pa[i]);
      b_i[i] = $signed(pb[i]);
      dv[i]  = b_i[i] - a_i[i];
      fv[i]  = a_i[i] - wide_t'($signed(pc[i]));
      a += dv[i] * dv[i];
      h += dv[i] * fv[i];
      c += fv[i] * fv[i];
    end
    rr = wide_t'({1'b0, model_radius});
    c -= rr * rr;
    if (a == 0) begin
      e = '{0, 0, 0, ST_DEGEN, 1'b0};
      found.insert(found.size(), e);
      n_degen++;
    end else begin
      disc = h * h - a * c;
      if (disc >= 0) begin
        s = isqrt(disc);
        roots = (disc == 0) ? 1 : 2;
        for (int k = 0; k < roots; k++) begin
          num  = (k == 0) ? -h + s : -h - s;
          keep = 1'b1;
          for (int i = 0; i < 3; i++) begin
            prod = dv[i] * num;
            q = ((prod < 0 ? -prod : prod) * 2 + a) / (2 * a);
            if (prod < 0) q = -q;
            p = a_i[i] + q;
            if (!(a_i[i] - TOL <= p && p <= b_i[i] + TOL) &&
                !(b_i[i] - TOL <= p && p <= a_i[i] + TOL)) keep = 1'b0;
            case (i)
              0: e.hx = clamp(p);
              1: e.hy = clamp(p);
              default: e.hz = clamp(p);
            endcase
          end
          e.st = ST_POINT; e.lst = 1'b0;
          if (keep) begin
            found.insert(found.size(), e);
            n_points++;
          end
        end
      end
      if (found.size() == 0) begin
        e = '{0, 0, 0, ST_NONE, 1'b0};
        found.insert(found.size(), e);
        n_misses++;
      end
    end
    found[found.size()-1].lst = 1'b1;
    foreach (found[j]) pending_hits.insert(pending_hits.size(), found[j]);
  endtask

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_query(logic [CW-1:0] pa[3], logic [CW-1:0] pb[3],
                            logic [CW-1:0] pc[3]);
    logic ok;
    start = 1'b1;
    {in_start_x, in_start_y, in_start_z} = {pa[0], pa[1], pa[2]};
    {in_end_x, in_end_y, in_end_z}       = {pb[0], pb[1], pb[2]};
    {in_center_x, in_center_y, in_center_z} = {pc[0], pc[1], pc[2]};
    forever begin
      ok = !busy;
      @(posedge clk);
      if (ok) break;
      @(negedge clk);
    end
    predict_hits(pa, pb, pc);
    n_queries++;
    @(negedge clk);
  endtask

  task automatic idle_for(int n);
    start = 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic random_gap(bit quiet);
    int r;
    if (quiet) return;
    r = $urandom_range(0, 99);
    if (r < 65) return;
    if (r < 95) idle_for($urandom_range(1, 4));
    else idle_for($urandom_range(20, 200));
  endtask

  task automatic drain();
    start = 1'b0;
    while (pending_hits.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic write_radius(logic [RW-1:0] r);
    drain();
    cfg_radius = r;
    cfg_we = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
    model_radius = r;
  endtask

  function automatic logic [CW-1:0] q16(int v);
    return CW'(v * 65536);
  endfunction

  function automatic logic [CW-1:0] any_coord();
    case ($urandom_range(0, 5))
      0: return 32'h80000000;
      1: return 32'h7fffffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed();
    logic [CW-1:0] pa[3], pb[3], pc[3];
    // degenerate segment
    pa = '{q16(1), q16(2), q16(3)}; pb = pa; pc = '{0, 0, 0};
    send_query(pa, pb, pc);
    // segment through the unit sphere: two hits
    pa = '{q16(-2), 0, 0}; pb = '{q16(2), 0, 0};
    send_query(pa, pb, pc);
    // tangent line: one root
    pa = '{q16(-2), q16(1), 0}; pb = '{q16(2), q16(1), 0};
    send_query(pa, pb, pc);
    // line misses the sphere
    pa = '{q16(-2), q16(5), 0}; pb = '{q16(2), q16(5), 0};
    send_query(pa, pb, pc);
    // segment wholly inside: both roots off the segment
    pa = '{-(q16(1) / 4), 0, 0}; pb = '{q16(1) / 4, 0, 0};
    send_query(pa, pb, pc);
    // segment from the centre crosses the surface: one root kept
    pa = '{0, 0, 0}; pb = '{q16(3), 0, 0};
    send_query(pa, pb, pc);
    // just short of the surface, within tolerance
    pa = '{0, 0, 0}; pb = '{q16(1) - 3, 0, 0};
    send_query(pa, pb, pc);
    idle_for(1);
    // range extremes
    pa = '{32'h80000000, 32'h80000000, 32'h80000000};
    pb = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff};
    pc = '{32'h7fffffff, 32'h80000000, 0};
    send_query(pa, pb, pc);
    pc = '{0, 0, 0};
    send_query(pa, pb, pc);
    send_query(pb, pa, pa);
  endtask

  task automatic test_extremes();
    logic [CW-1:0] pa[3], pb[3], pc[3];
    write_radius({RW{1'b1}});
    pa = '{32'h80000000, 0, 0}; pb = '{32'h7fffffff, 0, 0}; pc = '{0, 0, 0};
    send_query(pa, pb, pc);
    pa = '{32'h80000000, 32'h80000000, 32'h80000000};
    pb = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff};
    send_query(pa, pb, pc);
    pc = '{32'h7fffffff, 32'h7fffffff, 32'h80000000};
    send_query(pa, pb, pc);
    write_radius('0);
    pa = '{q16(-1), 0, 0}; pb = '{q16(1), 0, 0};
    send_query(pa, pb, pc);
    send_query(pb, pb, pc);
  endtask

  task automatic test_random(int count, bit quiet);
    logic [CW-1:0] pa[3], pb[3], pc[3];
    int span, r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        // segment around the sphere, random scale
        span = $urandom_range(4, 24);
        for (int i = 0; i < 3; i++) begin
          pc[i] = CW'($signed($urandom) >>> (CW - span));
          pa[i] = pc[i] + CW'($signed($urandom) >>> (CW - span - 1));
          pb[i] = pc[i] + CW'($signed($urandom) >>> (CW - span - 1));
        end
        if ($urandom_range(0, 15) == 0) pb = pa;
      end else begin
        for (int i = 0; i < 3; i++) begin
          pa[i] = any_coord(); pb[i] = any_coord(); pc[i] = any_coord();
        end
      end
      send_query(pa, pb, pc);
      random_gap(quiet);
    end
  endtask

  always @(posedge clk) begin
    hit_t e;
    if (rst_n && out_valid) begin
      n_results++;
      if (pending_hits.size() == 0) begin
        $error("result with no query outstanding");
        n_errors++;
      end else begin
        e = pending_hits.pop_front();
        if (out_hit_x !== e.hx) begin
          $error("hit_x exp %h got %h", e.hx, out_hit_x); n_errors++;
        end
        if (out_hit_y !== e.hy) begin
          $error("hit_y exp %h got %h", e.hy, out_hit_y); n_errors++;
        end
        if (out_hit_z !== e.hz) begin
          $error("hit_z exp %h got %h", e.hz, out_hit_z); n_errors++;
        end
        if (out_status !== e.st) begin
          $error("status exp %0d got %0d", e.st, out_status); n_errors++;
        end
        if (out_last !== e.lst) begin
          $error("last exp %0d got %0d", e.lst, out_last); n_errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || out_valid || (start && !busy) || cfg_we) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles > 5000) begin
      $display("watchdog: no transfer for %0d cycles", idle_cycles);
      $display("FAIL segment_sphere_intersection_unit");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0; start = 1'b0; cfg_we = 1'b0; cfg_radius = '0;
    {in_start_x, in_start_y, in_start_z} = '0;
    {in_end_x, in_end_y, in_end_z} = '0;
    {in_center_x, in_center_y, in_center_z} = '0;
    model_radius = RADIUS_RST;
    n_errors = 0; n_queries = 0; n_results = 0; idle_cycles = 0;
    n_points = 0; n_misses = 0; n_degen = 0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_extremes();
    write_radius(RW'(65536));
    test_random(250, 1'b0);
    write_radius(RW'($urandom_range(1, 1 << 22)));
    test_random(200, 1'b1);
    write_radius(RW'($urandom));
    test_random(150, 1'b0);
    write_radius(RW'(1 << 30) | RW'($urandom));
    test_random(100, 1'b0);
    write_radius(RW'($urandom_range(1, 4000)));
    test_random(130, 1'b0);
    drain();
    $display("covered %0d queries, %0d results: %0d points, %0d misses, %0d degenerate",
             n_queries, n_results, n_points, n_misses, n_degen);
    if (n_errors == 0) $display("PASS segment_sphere_intersection_unit");
    else $display("FAIL segment_sphere_intersection_unit");
    $finish;
  end
endmodule

### sim.f
rtl/ssi_pkg.sv
rtl/ssi_sqrt.sv
rtl/ssi_front.sv
rtl/ssi_fifo.sv
rtl/ssi_div.sv
rtl/ssi_back.sv
rtl/segment_sphere_intersection_unit.sv
test/tb.sv
